// File: rtl/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tgarle_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgRleMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFourByte   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPixelCount = 2'd2;

  localparam logic [7:0] AlphaOpaque = 8'd255;
  localparam logic [6:0] CountMask   = 7'd127;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] run_length;
    logic       image_done;
  } pix_t;

endpackage

// File: rtl/tgarle_parser.sv
// Byte parser: config registers, packet/pixel state, run computation.
module tgarle_parser import tgarle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                byte_we_i,
  input  logic [7:0]          body_byte_i,
  output logic                res_valid_o,
  output pix_t                res_o
);

  logic        rle_mode_q, rle_mode_d;
  logic        four_byte_q, four_byte_d;
  logic [31:0] pixel_count_q, pixel_count_d;

  logic        expect_hdr_q, expect_hdr_d;
  logic        is_repeat_q, is_repeat_d;
  logic [7:0]  pkt_left_q, pkt_left_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [7:0]  bytes_q [4];
  logic [7:0]  bytes_d [4];
  logic [31:0] pixels_left_q, pixels_left_d;

  logic        restart;
  logic [1:0]  last_pos;
  logic [7:0]  run_raw;
  logic [7:0]  run_clamped;
  logic [7:0]  pkt_next;
  logic        run_exceeds;
  logic [31:0] left_after;

  assign last_pos = four_byte_q ? 2'd3 : 2'd2;

  always_comb begin
    rle_mode_d    = rle_mode_q;
    four_byte_d   = four_byte_q;
    pixel_count_d = pixel_count_q;
    restart       = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRleMode: begin
          rle_mode_d = cfg_data_i[0];
          restart    = 1'b1;
        end
        CfgFourByte: begin
          four_byte_d = cfg_data_i[0];
          restart     = 1'b1;
        end
        CfgPixelCount: begin
          pixel_count_d = cfg_data_i;
          restart       = 1'b1;
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    // run for a completed pixel, before clamping
    pkt_next = pkt_left_q;
    run_raw  = 8'd1;
    if (rle_mode_q) begin
      if (is_repeat_q) begin
        run_raw  = (pkt_left_q == 8'd0) ? 8'd1 : pkt_left_q;
        pkt_next = 8'd0;
      end else if (pkt_left_q != 8'd0) begin
        pkt_next = pkt_left_q - 8'd1;
      end
    end
    run_exceeds = (pixels_left_q[31:8] == 24'd0) && (pixels_left_q[7:0] < run_raw);
    run_clamped = run_exceeds ? pixels_left_q[7:0] : run_raw;
    left_after  = pixels_left_q - {24'd0, run_clamped};
  end

  always_comb begin
    expect_hdr_d  = expect_hdr_q;
    is_repeat_d   = is_repeat_q;
    pkt_left_d    = pkt_left_q;
    byte_pos_d    = byte_pos_q;
    bytes_d       = bytes_q;
    pixels_left_d = pixels_left_q;
    res_valid_o   = 1'b0;

    if (restart) begin
      expect_hdr_d  = 1'b1;
      is_repeat_d   = 1'b0;
      pkt_left_d    = 8'd0;
      byte_pos_d    = 2'd0;
      bytes_d[0]    = 8'd0;
      bytes_d[1]    = 8'd0;
      bytes_d[2]    = 8'd0;
      bytes_d[3]    = AlphaOpaque;
      pixels_left_d = pixel_count_d;
    end else if (byte_we_i && (pixels_left_q != 32'd0)) begin
      if (rle_mode_q && expect_hdr_q) begin
        is_repeat_d  = body_byte_i[7];
        pkt_left_d   = {1'b0, body_byte_i[6:0] & CountMask} + 8'd1;
        expect_hdr_d = 1'b0;
      end else begin
        bytes_d[byte_pos_q] = body_byte_i;
        if (byte_pos_q < last_pos) begin
          byte_pos_d = byte_pos_q + 2'd1;
        end else begin
          byte_pos_d    = 2'd0;
          res_valid_o   = 1'b1;
          pkt_left_d    = pkt_next;
          if (rle_mode_q && (pkt_next == 8'd0)) expect_hdr_d = 1'b1;
          pixels_left_d = left_after;
        end
      end
    end
  end

  assign res_o.red        = bytes_d[2];
  assign res_o.green      = bytes_d[1];
  assign res_o.blue       = bytes_d[0];
  assign res_o.alpha      = bytes_d[3];
  assign res_o.run_length = run_clamped;
  assign res_o.image_done = (left_after == 32'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_mode_q    <= 1'b0;
      four_byte_q   <= 1'b0;
      pixel_count_q <= 32'd0;
      expect_hdr_q  <= 1'b1;
      is_repeat_q   <= 1'b0;
      pkt_left_q    <= 8'd0;
      byte_pos_q    <= 2'd0;
      bytes_q[0]    <= 8'd0;
      bytes_q[1]    <= 8'd0;
      bytes_q[2]    <= 8'd0;
      bytes_q[3]    <= AlphaOpaque;
      pixels_left_q <= 32'd0;
    end else begin
      rle_mode_q    <= rle_mode_d;
      four_byte_q   <= four_byte_d;
      pixel_count_q <= pixel_count_d;
      expect_hdr_q  <= expect_hdr_d;
      is_repeat_q   <= is_repeat_d;
      pkt_left_q    <= pkt_left_d;
      byte_pos_q    <= byte_pos_d;
      bytes_q       <= bytes_d;
      pixels_left_q <= pixels_left_d;
    end
  end

endmodule

// File: rtl/tgarle_out_buf.sv
// Two-entry result buffer between the parser and the output channel.
module tgarle_out_buf import tgarle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  pix_t push_data_i,
  output logic full_o,
  output logic valid_o,
  input  logic ready_i,
  output pix_t data_o
);

  pix_t       slot_q [2];
  logic       rd_ptr_q, rd_ptr_d;
  logic       wr_ptr_q, wr_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = cnt_q[1];
  assign pop     = valid_o && ready_i;
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q ^ pop;
    wr_ptr_d = wr_ptr_q ^ push_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/tga_rle_pixel_decoder.sv
// Top level: TGA image-body decoder producing RGBA pixel runs.
// A pixel's result is registered in the buffer on its last byte, behind waiting ones.
// Throughput: one byte per cycle; the parser updates all state in one pass per byte.
// Output side holds two results, so input stalls only while both are waiting.
// Reset (rst_ni low, async): config clears to zero, decoder waits for a packet header,
// pixels remaining is zero, so bytes are dropped until pixel_count is written.
module tga_rle_pixel_decoder import tgarle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // body byte channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          body_byte_i,
  // pixel run channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o,
  output logic [7:0]          alpha_o,
  output logic [7:0]          run_length_o,
  output logic                image_done_o
);

  logic byte_we;
  logic buf_full;
  logic res_valid;
  pix_t res;
  pix_t head;

  // Config writes are always accepted; any valid index restarts the image.
  assign cfg_ready_o = 1'b1;

  // A byte transfer may happen whenever the buffer has a free slot,
  // even while an earlier run still waits on the output.
  assign in_ready_o = !buf_full;
  assign byte_we    = in_valid_i && in_ready_o;

  tgarle_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .byte_we_i   (byte_we),
    .body_byte_i (body_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tgarle_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .data_o      (head)
  );

  assign red_o        = head.red;
  assign green_o      = head.green;
  assign blue_o       = head.blue;
  assign alpha_o      = head.alpha;
  assign run_length_o = head.run_length;
  assign image_done_o = head.image_done;

endmodule
